// File: rtl/tbl_pkg.sv
// ============================================================================
// Token bucket limiter package
// Field widths, register indexes, request codes and the transaction types
// shared by the token bucket limiter and its serial multiplier.
// ============================================================================
package tbl_pkg;

    // Default values for the top-level parameters.
    localparam int unsigned DEF_TICKS_PER_SECOND = 1000000;
    localparam int unsigned DEF_TIME_WIDTH       = 48;
    localparam int unsigned DEF_TOKEN_WIDTH      = 32;

    // Fixed field widths of the transaction payloads.
    localparam int unsigned AMOUNT_W = 32;
    localparam int unsigned TS_W     = 48;
    localparam int unsigned WAIT_W   = 52;
    localparam int unsigned TOKENS_W = 32;

    // Configuration port.
    localparam int unsigned RATE_W     = 32;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd1;

    // Request types.
    localparam logic REQ_CONSUME = 1'b0;
    localparam logic REQ_ADD     = 1'b1;

    // Saturation value of the reported wait.
    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    typedef struct packed {
        logic                req_type;
        logic [AMOUNT_W-1:0] amount;
        logic [TS_W-1:0]     timestamp_us;
    } in_item_t;

    typedef struct packed {
        logic                granted;
        logic [WAIT_W-1:0]   wait_ticks;
        logic [TOKENS_W-1:0] whole_tokens;
    } out_item_t;

endpackage

// File: rtl/tbl_serial_mul.sv
// ============================================================================
// Token bucket limiter refill multiplier
// Bit-serial shift-and-add product of the elapsed time and the refill rate,
// one rate bit per cycle from the top, always over all rate bits; the partial
// product is frozen as soon as it passes the room.
// ============================================================================
module tbl_serial_mul
    import tbl_pkg::*;
#(
    parameter int unsigned DIFF_W  = DEF_TIME_WIDTH,
    parameter int unsigned LEVEL_W = 52
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIFF_W-1:0]  diff,
    input  logic [RATE_W-1:0]  rate,
    input  logic [LEVEL_W-1:0] room,
    output logic               done,
    output logic               over,
    output logic [LEVEL_W-1:0] prod
);

    // The accumulator stays at or below the room until it overflows, so one
    // doubling plus one addend must fit.
    localparam int unsigned ACC_W = ((LEVEL_W + 1 > DIFF_W) ? LEVEL_W + 1 : DIFF_W) + 1;
    localparam int unsigned CNT_W = $clog2(RATE_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               over_reg, over_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RATE_W-1:0]  mult_reg, mult_next;
    logic [DIFF_W-1:0]  diff_reg, diff_next;
    logic [LEVEL_W-1:0] room_reg, room_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   acc_step;

    // One step: double the partial product and add the time difference when
    // the current rate bit is set.
    assign acc_step = {acc_reg[ACC_W-2:0], 1'b0}
                    + (mult_reg[RATE_W-1] ? ACC_W'(diff_reg) : '0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        over_next = over_reg;
        cnt_next  = cnt_reg;
        mult_next = mult_reg;
        diff_next = diff_reg;
        room_next = room_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            over_next = 1'b0;
            cnt_next  = CNT_W'(RATE_W - 1);
            mult_next = rate;
            diff_next = diff;
            room_next = room;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            mult_next = {mult_reg[RATE_W-2:0], 1'b0};
            if (!over_reg)
            begin
                acc_next = acc_step;
                if (acc_step > ACC_W'(room_reg))
                begin
                    over_next = 1'b1;
                end
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            over_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            over_reg <= over_next;
        end
    end

    // Operand and accumulator shift registers.
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        mult_reg <= mult_next;
        diff_reg <= diff_next;
        room_reg <= room_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign over = over_reg;
    assign prod = acc_reg[LEVEL_W-1:0];

endmodule

// File: rtl/tbl_serial_div.sv
// ============================================================================
// Token bucket limiter serial divider
// Restoring division, one quotient bit per cycle; the dividend register
// shifts left and collects the quotient bits as it empties.
// ============================================================================
module tbl_serial_div #(
    parameter int unsigned DIVIDEND_W = 52,
    parameter int unsigned DIVISOR_W  = 32
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] work_reg, work_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_sub;
    logic                  fits;

    // Bring down the next dividend bit and try the subtraction.
    assign trial     = {rem_reg, work_reg[DIVIDEND_W-1]};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign fits      = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = CNT_W'(DIVIDEND_W - 1);
            work_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

// File: rtl/token_bucket_limiter.sv
// ============================================================================
// Token bucket limiter
// Keeps the bucket level in ticks-scaled tokens, refills consume requests by
// rate times elapsed ticks, grants or refuses them and reports the wait.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  --------------------------------
//  in       sink       in_valid / in_stall  in_item  (in_item_t)
//  out      source     out_valid/out_stall  out_item (out_item_t)
//  cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One request is processed at a time. A consume transaction passes through the
//  bit-serial refill multiplier, then the serial dividers, which produce the
//  wait and the whole-token count side by side. An add transaction skips the
//  multiplier and goes straight to the dividers.
//  Reset clears the configuration, marks the bucket unprimed and empties the
//  output register; no clearing pass is needed. A stalled result waits in the
//  output register while the next request is already accepted and worked on.
//
module token_bucket_limiter
    import tbl_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = DEF_TICKS_PER_SECOND,
    parameter int unsigned TIME_WIDTH       = DEF_TIME_WIDTH,
    parameter int unsigned TOKEN_WIDTH      = DEF_TOKEN_WIDTH
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned SCALE_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int unsigned LEVEL_W = TOKEN_WIDTH + SCALE_W;
    localparam int unsigned TW      = (TIME_WIDTH < TS_W) ? TIME_WIDTH : TS_W;
    localparam int unsigned EXT_W   = (LEVEL_W > WAIT_W) ? LEVEL_W : WAIT_W;

    localparam logic [LEVEL_W-1:0] TPS_L = LEVEL_W'(TICKS_PER_SECOND);
    localparam logic [SCALE_W-1:0] TPS_S = SCALE_W'(TICKS_PER_SECOND);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOAD   = 4'd1;
    localparam logic [3:0] ST_PREP   = 4'd2;
    localparam logic [3:0] ST_MUL    = 4'd3;
    localparam logic [3:0] ST_UPDATE = 4'd4;
    localparam logic [3:0] ST_DECIDE = 4'd5;
    localparam logic [3:0] ST_DSTART = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic                   primed_reg, primed_next;
    logic [LEVEL_W-1:0]     full_reg, full_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_item_reg, out_item_next;

    logic                   req_reg, req_next;
    logic [TOKEN_WIDTH-1:0] amount_reg, amount_next;
    logic [TW-1:0]          now_reg, now_next;
    logic [TW-1:0]          last_time_reg, last_time_next;
    logic [TW-1:0]          diff_reg, diff_next;
    logic [LEVEL_W-1:0]     need_reg, need_next;
    logic [LEVEL_W-1:0]     level_reg, level_next;
    logic                   below_full_reg, below_full_next;
    logic                   granted_reg, granted_next;
    logic                   refused_reg, refused_next;

    logic                   mul_start;
    logic                   mul_done;
    logic                   mul_over;
    logic [LEVEL_W-1:0]     mul_prod;
    logic [LEVEL_W-1:0]     room;

    logic                   div_start;
    logic                   wait_done;
    logic                   tok_done;
    logic [LEVEL_W-1:0]     wait_dividend;
    logic [LEVEL_W-1:0]     wait_quot;
    logic [LEVEL_W-1:0]     tok_quot;
    logic [EXT_W-1:0]       wait_ext;
    logic                   wait_sat;
    logic [LEVEL_W:0]       add_sum;

    // Free space in the bucket; only meaningful while the level is below full.
    assign room          = full_reg - level_reg;
    assign wait_dividend = need_reg - level_reg;
    assign add_sum       = {1'b0, level_reg} + {1'b0, need_reg};

    // Wait quotient saturated to the width of the result field.
    assign wait_ext = EXT_W'(wait_quot);
    assign wait_sat = (wait_ext >> WAIT_W) != '0;

    tbl_serial_mul #(
        .DIFF_W  (TW),
        .LEVEL_W (LEVEL_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .diff  (diff_reg),
        .rate  (rate_reg),
        .room  (room),
        .done  (mul_done),
        .over  (mul_over),
        .prod  (mul_prod)
    );

    tbl_serial_div #(
        .DIVIDEND_W (LEVEL_W),
        .DIVISOR_W  (RATE_W)
    ) u_wait_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (wait_dividend),
        .divisor  (rate_reg),
        .done     (wait_done),
        .quotient (wait_quot)
    );

    tbl_serial_div #(
        .DIVIDEND_W (LEVEL_W),
        .DIVISOR_W  (SCALE_W)
    ) u_tok_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (level_reg),
        .divisor  (TPS_S),
        .done     (tok_done),
        .quotient (tok_quot)
    );

    // Sequencer, configuration writes and output register.
    always_comb
    begin
        state_next      = state_reg;
        primed_next     = primed_reg;
        full_next       = full_reg;
        rate_next       = rate_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        req_next        = req_reg;
        amount_next     = amount_reg;
        now_next        = now_reg;
        last_time_next  = last_time_reg;
        diff_next       = diff_reg;
        need_next       = need_reg;
        level_next      = level_reg;
        below_full_next = below_full_reg;
        granted_next    = granted_reg;
        refused_next    = refused_reg;
        mul_start       = 1'b0;
        div_start       = 1'b0;

        // The full level is kept pre-scaled, so a capacity write multiplies.
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CAPACITY: full_next = LEVEL_W'(cfg_data[TOKEN_WIDTH-1:0]) * TPS_L;
                REG_RATE:     rate_next = cfg_data;
                default:      ;
            endcase
        end

        // The downstream side has taken the waiting result.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = in_item.req_type;
                    amount_next = in_item.amount[TOKEN_WIDTH-1:0];
                    now_next    = in_item.timestamp_us[TW-1:0];
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                need_next    = LEVEL_W'(amount_reg) * TPS_L;
                diff_next    = (now_reg >= last_time_reg) ? now_reg - last_time_reg
                                                          : last_time_reg - now_reg;
                granted_next = 1'b0;
                refused_next = 1'b0;
                // The first request after reset finds the bucket full.
                if (!primed_reg)
                begin
                    level_next  = full_reg;
                    primed_next = 1'b1;
                end
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (req_reg == REQ_ADD)
                begin
                    level_next = (add_sum > {1'b0, full_reg}) ? full_reg
                                                              : add_sum[LEVEL_W-1:0];
                    state_next = ST_DSTART;
                end
                else
                begin
                    below_full_next = level_reg < full_reg;
                    mul_start       = 1'b1;
                    state_next      = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // A full bucket, or a refill beyond the room, leaves it full.
                level_next     = (!below_full_reg || mul_over) ? full_reg
                                                               : level_reg + mul_prod;
                last_time_next = now_reg;
                state_next     = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (need_reg <= level_reg)
                begin
                    level_next   = level_reg - need_reg;
                    granted_next = 1'b1;
                end
                else
                begin
                    refused_next = 1'b1;
                end
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (tok_done && wait_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_item_next.granted      = granted_reg;
                    out_item_next.whole_tokens = TOKENS_W'(tok_quot[TOKEN_WIDTH-1:0]);
                    if (!refused_reg)
                    begin
                        out_item_next.wait_ticks = '0;
                    end
                    else if (rate_reg == '0 || wait_sat)
                    begin
                        out_item_next.wait_ticks = WAIT_MAX;
                    end
                    else
                    begin
                        out_item_next.wait_ticks = wait_ext[WAIT_W-1:0];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and configuration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            full_reg      <= '0;
            rate_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            full_reg      <= full_next;
            rate_reg      <= rate_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request, bucket and result registers.
    always_ff @(posedge clk)
    begin
        out_item_reg   <= out_item_next;
        req_reg        <= req_next;
        amount_reg     <= amount_next;
        now_reg        <= now_next;
        last_time_reg  <= last_time_next;
        diff_reg       <= diff_next;
        need_reg       <= need_next;
        level_reg      <= level_next;
        below_full_reg <= below_full_next;
        granted_reg    <= granted_next;
        refused_reg    <= refused_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

endmodule
